// File: hw/rtl/maze_backtracker_generator_core_assert.svh
// Assertion macros for the maze carver RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef MAZE_BACKTRACKER_GENERATOR_CORE_ASSERT_SVH
`define MAZE_BACKTRACKER_GENERATOR_CORE_ASSERT_SVH

// Property checked at every edge outside reset.
`define MBG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mbg: assertion failed");

// Condition in one cycle implies a consequence in the next one.
`define MBG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mbg: assertion failed");

`endif

// File: hw/rtl/mbg_pkg.sv
// Types and constants of the maze carver core.
// No dependencies; imported by maze_backtracker_generator_core.
package mbg_pkg;

  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;
  localparam int GRID_LIMIT   = 64;   // largest grid side in use

  localparam int IN_DATA_W  = 16;   // cell_x, cell_y, rand_pick, zero fill
  localparam int IN_USER_W  = 2;    // req_type
  localparam int OUT_DATA_W = 24;   // pos_x, pos_y, direction, cell_value
  localparam int OUT_USER_W = 3;    // event_res
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // request kinds
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_STEP  = 2'd1;

  // result events
  localparam logic [2:0] EV_STARTED     = 3'd0;
  localparam logic [2:0] EV_CARVED      = 3'd1;
  localparam logic [2:0] EV_BACKTRACKED = 3'd2;
  localparam logic [2:0] EV_FINISHED    = 3'd3;
  localparam logic [2:0] EV_READ_REPLY  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  localparam logic [3:0] DIR_UP    = 4'b0001;
  localparam logic [3:0] DIR_RIGHT = 4'b0010;
  localparam logic [3:0] DIR_DOWN  = 4'b0100;
  localparam logic [3:0] DIR_LEFT  = 4'b1000;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_READW,
    ST_CUR,
    ST_CURW,
    ST_PROBE,
    ST_CHECK,
    ST_WR_CUR,
    ST_WR_NEW,
    ST_EMIT
  } state_e;

  // neighbour lookup result
  typedef struct packed {
    logic       ok;
    logic [5:0] x;
    logic [5:0] y;
  } nb_t;

endpackage

// File: hw/rtl/maze_backtracker_generator_core.sv
// Depth-first maze carver: sequencer around one cell-byte memory.
// Depends on mbg_pkg and maze_backtracker_generator_core_assert.svh.

// A read item passes through a read, a wait and an emit state before its word
// reaches the output. A step while carving reads the current cell, then for
// each neighbour probed (up to four) only probes it if it lies outside the grid,
// or reads and checks it if inside, then either writes two cells (carve) or
// reads the cell reached. A step after the maze is finished passes through the
// same read states. A start clears all MAX_COLS*MAX_ROWS entries of the cell
// memory, one entry a cycle, before its result is emitted; the same clearing
// pass runs after reset, and no word is accepted until it is done.
// Configuration writes are taken in any cycle. A finished result waits in the
// output register while the next word is taken.
`include "maze_backtracker_generator_core_assert.svh"

module maze_backtracker_generator_core #(
  parameter int MAX_COLS = mbg_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = mbg_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mbg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mbg_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [5:0] cell_x, [11:6] cell_y, [13:12] rand_pick, [15:14] zero
  input  logic [mbg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] req_type
  input  logic [mbg_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [5:0] pos_x, [11:6] pos_y, [15:12] direction, [23:16] cell_value
  output logic [mbg_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // [2:0] event_res
  output logic [mbg_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

  import mbg_pkg::*;

  localparam int STORE_SIZE = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int IDX_W      = 14;   // x + cols*y with 6-bit coordinates, 7-bit cols
  localparam logic [6:0] COLS_HI = (MAX_COLS < GRID_LIMIT) ? 7'(MAX_COLS) : 7'(GRID_LIMIT);
  localparam logic [6:0] ROWS_HI = (MAX_ROWS < GRID_LIMIT) ? 7'(MAX_ROWS) : 7'(GRID_LIMIT);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_SIZE - 1);

  function automatic logic [6:0] limit_dim(input logic [6:0] v, input logic [6:0] hi);
    logic [6:0] r;
    if (v == 7'd0) r = 7'd1;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [5:0] sat_coord(input logic [5:0] v, input logic [6:0] n);
    logic [6:0] last;
    last = n - 7'd1;
    return ({1'b0, v} >= n) ? last[5:0] : v;
  endfunction

  function automatic nb_t neighbour(input logic [5:0] x, input logic [5:0] y,
                                    input logic [3:0] d, input logic [6:0] w,
                                    input logic [6:0] h);
    nb_t r;
    r.ok = 1'b0;
    r.x  = x;
    r.y  = y;
    unique case (d)
      DIR_UP: begin
        r.ok = (y != 6'd0);
        r.y  = y - 6'd1;
      end
      DIR_RIGHT: begin
        r.ok = (({1'b0, x} + 7'd1) < w);
        r.x  = x + 6'd1;
      end
      DIR_DOWN: begin
        r.ok = (({1'b0, y} + 7'd1) < h);
        r.y  = y + 6'd1;
      end
      DIR_LEFT: begin
        r.ok = (x != 6'd0);
        r.x  = x - 6'd1;
      end
      default: r.ok = 1'b0;
    endcase
    if (!r.ok) begin
      r.x = x;
      r.y = y;
    end
    return r;
  endfunction

  // configuration
  logic [6:0] grid_width_q, grid_height_q;
  logic [6:0] cols, rows;

  // sequencer
  state_e            state_q, state_d;
  logic [1:0]        k_q, k_d;
  logic [3:0]        d_q, d_d;
  logic              active_q, active_d;
  logic [5:0]        walker_x_q, walker_x_d, walker_y_q, walker_y_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic              clr_emit_q, clr_emit_d;

  // payload
  logic [7:0]        cur_q, cur_d;
  logic [5:0]        pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [2:0]        ev_q, ev_d;
  logic [3:0]        dir_q, dir_d;
  logic [7:0]        val_q, val_d;

  // output register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;
  logic                  out_load;

  // memory port
  logic [7:0]        mem [STORE_SIZE];
  logic [7:0]        rdata_q;
  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_addr;
  logic [5:0]        ax, ay;
  logic [IDX_W-1:0]  idx_full;

  // input fields
  logic [1:0] in_req;
  logic [5:0] in_x, in_y;
  logic [1:0] in_pick;
  logic       in_acc;

  nb_t        nb_fwd, nb_back;
  logic [3:0] back_ptr;
  logic [3:0] opp;

  assign in_req  = s_axis_tuser[1:0];
  assign in_x    = s_axis_tdata[5:0];
  assign in_y    = s_axis_tdata[11:6];
  assign in_pick = s_axis_tdata[13:12];

  assign cols = limit_dim(grid_width_q, COLS_HI);
  assign rows = limit_dim(grid_height_q, ROWS_HI);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign nb_fwd   = neighbour(walker_x_q, walker_y_q, d_q, cols, rows);
  assign back_ptr = cur_q[7:4];
  assign nb_back  = neighbour(walker_x_q, walker_y_q, back_ptr, cols, rows);
  assign opp      = {d_q[1:0], d_q[3:2]};

  assign idx_full = IDX_W'(ax) + IDX_W'(cols) * IDX_W'(ay);
  assign mem_addr = (state_q == ST_CLEAR) ? clr_cnt_q : ADDR_W'(idx_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= 7'(GRID_LIMIT);
      grid_height_q <= 7'(GRID_LIMIT);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_q <= mem[mem_addr];
  end

  always_comb begin
    logic probe_fail;
    state_d    = state_q;
    k_d        = k_q;
    d_d        = d_q;
    active_d   = active_q;
    walker_x_d = walker_x_q;
    walker_y_d = walker_y_q;
    clr_cnt_d  = clr_cnt_q;
    clr_emit_d = clr_emit_q;
    cur_d      = cur_q;
    pos_x_d    = pos_x_q;
    pos_y_d    = pos_y_q;
    ev_d       = ev_q;
    dir_d      = dir_q;
    val_d      = val_q;
    mem_we     = 1'b0;
    mem_wdata  = 8'h00;
    ax         = pos_x_q;
    ay         = pos_y_q;
    out_load   = 1'b0;
    probe_fail = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_cnt_q == CLR_LAST) begin
          state_d = clr_emit_q ? ST_EMIT : ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          dir_d = 4'd0;
          unique case (in_req)
            REQ_START: begin
              walker_x_d = sat_coord(in_x, cols);
              walker_y_d = sat_coord(in_y, rows);
              pos_x_d    = sat_coord(in_x, cols);
              pos_y_d    = sat_coord(in_y, rows);
              active_d   = 1'b1;
              ev_d       = EV_STARTED;
              val_d      = 8'h00;
              clr_cnt_d  = '0;
              clr_emit_d = 1'b1;
              state_d    = ST_CLEAR;
            end
            REQ_STEP: begin
              walker_x_d = sat_coord(walker_x_q, cols);
              walker_y_d = sat_coord(walker_y_q, rows);
              pos_x_d    = sat_coord(walker_x_q, cols);
              pos_y_d    = sat_coord(walker_y_q, rows);
              ev_d       = EV_FINISHED;
              k_d        = 2'd0;
              d_d        = 4'b0001 << in_pick;
              state_d    = active_q ? ST_CUR : ST_READ;
            end
            default: begin
              pos_x_d = sat_coord(in_x, cols);
              pos_y_d = sat_coord(in_y, rows);
              ev_d    = EV_READ_REPLY;
              state_d = ST_READ;
            end
          endcase
        end
      end
      ST_READ: state_d = ST_READW;
      ST_READW: begin
        val_d   = rdata_q;
        state_d = ST_EMIT;
      end
      ST_CUR: begin
        ax      = walker_x_q;
        ay      = walker_y_q;
        state_d = ST_CURW;
      end
      ST_CURW: begin
        cur_d   = rdata_q;
        state_d = ST_PROBE;
      end
      ST_PROBE: begin
        ax = nb_fwd.x;
        ay = nb_fwd.y;
        if (nb_fwd.ok) state_d = ST_CHECK;
        else probe_fail = 1'b1;
      end
      ST_CHECK: begin
        if (rdata_q == 8'h00) state_d = ST_WR_CUR;
        else probe_fail = 1'b1;
      end
      ST_WR_CUR: begin
        ax        = walker_x_q;
        ay        = walker_y_q;
        mem_we    = 1'b1;
        mem_wdata = cur_q | {4'd0, d_q};
        state_d   = ST_WR_NEW;
      end
      ST_WR_NEW: begin
        ax         = nb_fwd.x;
        ay         = nb_fwd.y;
        mem_we     = 1'b1;
        mem_wdata  = {opp, opp};
        walker_x_d = nb_fwd.x;
        walker_y_d = nb_fwd.y;
        pos_x_d    = nb_fwd.x;
        pos_y_d    = nb_fwd.y;
        ev_d       = EV_CARVED;
        dir_d      = d_q;
        val_d      = {opp, opp};
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // neighbour in this direction is taken or outside: try next, back up, or finish when there is no way back
    if (probe_fail) begin
      if (k_q != 2'd3) begin
        k_d     = k_q + 2'd1;
        d_d     = {d_q[2:0], d_q[3]};
        state_d = ST_PROBE;
      end else if (back_ptr == DIR_UP || back_ptr == DIR_RIGHT ||
                   back_ptr == DIR_DOWN || back_ptr == DIR_LEFT) begin
        walker_x_d = nb_back.x;
        walker_y_d = nb_back.y;
        pos_x_d    = nb_back.x;
        pos_y_d    = nb_back.y;
        ev_d       = EV_BACKTRACKED;
        dir_d      = back_ptr;
        state_d    = ST_READ;
      end else begin
        active_d = 1'b0;
        ev_d     = EV_FINISHED;
        dir_d    = 4'd0;
        state_d  = ST_READ;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      k_q         <= 2'd0;
      d_q         <= DIR_UP;
      active_q    <= 1'b0;
      walker_x_q  <= 6'd0;
      walker_y_q  <= 6'd0;
      clr_cnt_q   <= '0;
      clr_emit_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      d_q        <= d_d;
      active_q   <= active_d;
      walker_x_q <= walker_x_d;
      walker_y_q <= walker_y_d;
      clr_cnt_q  <= clr_cnt_d;
      clr_emit_q <= clr_emit_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    pos_x_q <= pos_x_d;
    pos_y_q <= pos_y_d;
    ev_q    <= ev_d;
    dir_q   <= dir_d;
    val_q   <= val_d;
    if (out_load) begin
      out_data_q <= {val_q, dir_q, pos_y_q, pos_x_q};
      out_user_q <= ev_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  `MBG_ASSERT_NEXT(a_carve_in_grid, state_q == ST_WR_NEW,
                   ({1'b0, walker_x_q} < cols) && ({1'b0, walker_y_q} < rows))
  `MBG_ASSERT_NEXT(a_clear_ends, (state_q == ST_CLEAR) && (clr_cnt_q == CLR_LAST),
                   (state_q == ST_IDLE) || (state_q == ST_EMIT))
  `MBG_ASSERT_NEXT(a_start_arms, in_acc && (in_req == REQ_START),
                   active_q && (state_q == ST_CLEAR))
  `MBG_ASSERT_NEXT(a_emit_holds, (state_q == ST_EMIT) && out_valid_q && !m_axis_tready,
                   (state_q == ST_EMIT) && $stable(out_data_q))

endmodule

// File: bench/tb_maze_backtracker_generator_core.sv
// Self-checking bench for maze_backtracker_generator_core: directed table, then random phases.
// A model carver predicts words with no tabled result. Depends on mbg_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_maze_backtracker_generator_core;
  import mbg_pkg::*;

  localparam int unsigned ITEM_TARGET    = 1350;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned PRINT_CAP      = 60;

  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_SPARE = 2'd3;   // unused code, answered as a read

  localparam logic [1:0] PICK_UP    = 2'd0;
  localparam logic [1:0] PICK_RIGHT = 2'd1;
  localparam logic [1:0] PICK_DOWN  = 2'd2;
  localparam logic [1:0] PICK_LEFT  = 2'd3;

  typedef struct packed {
    logic [2:0] ev;
    logic [5:0] px;
    logic [5:0] py;
    logic [3:0] dir;
    logic [7:0] val;
  } cell_result_t;

  typedef enum logic {ROW_GRID, ROW_WORD} row_kind_e;

  typedef struct {
    row_kind_e    kind;
    logic [6:0]   gw;
    logic [6:0]   gh;
    logic [1:0]   req;
    logic [5:0]   x;
    logic [5:0]   y;
    logic [1:0]   pick;
    bit           typed;
    cell_result_t want;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [5:0] cell_x, [11:6] cell_y, [13:12] rand_pick, [15:14] zero
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // [1:0] req_type
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [5:0] pos_x, [11:6] pos_y, [15:12] direction, [23:16] cell_value
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // [2:0] event_res
  logic [OUT_USER_W-1:0] m_axis_tuser;

  maze_backtracker_generator_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // carver state as the bench sees it
  logic [7:0]   cell_mem [GRID_LIMIT*GRID_LIMIT];
  int unsigned  walk_x = 0;
  int unsigned  walk_y = 0;
  bit           carving = 1'b0;
  logic [6:0]   grid_w_reg = 7'd64;
  logic [6:0]   grid_h_reg = 7'd64;

  cell_result_t awaited [$];
  plan_row_t    directed_plan [$];
  int unsigned  words_sent = 0;
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  bit           tx_calm = 1'b0;
  bit           rx_calm = 1'b0;
  logic         hold_req = 1'b0;
  logic         hold_ack = 1'b0;
  int unsigned  rx_wait = 0;
  int unsigned  rim_dims [7] = '{0, 1, 2, 63, 64, 65, 127};

  initial begin
    foreach (cell_mem[i]) cell_mem[i] = '0;
  end

  function automatic int unsigned fit_dim(logic [6:0] v);
    if (v < 1) return 1;
    if (v > GRID_LIMIT) return GRID_LIMIT;
    return v;
  endfunction

  function automatic int unsigned clamp(int unsigned v, int unsigned n);
    return (v >= n) ? n - 1 : v;
  endfunction

  // one move along a one-hot direction; 0 when it would leave the grid
  function automatic bit hop(int unsigned x, int unsigned y, logic [3:0] d,
                             output int unsigned nx, output int unsigned ny);
    int unsigned w, h;
    w = fit_dim(grid_w_reg);
    h = fit_dim(grid_h_reg);
    nx = x;
    ny = y;
    case (d)
      DIR_UP: begin
        if (y == 0) return 1'b0;
        ny = y - 1;
      end
      DIR_RIGHT: begin
        if (x + 1 >= w) return 1'b0;
        nx = x + 1;
      end
      DIR_DOWN: begin
        if (y + 1 >= h) return 1'b0;
        ny = y + 1;
      end
      DIR_LEFT: begin
        if (x == 0) return 1'b0;
        nx = x - 1;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic cell_result_t carve_predict(logic [1:0] req, logic [5:0] x,
                                                 logic [5:0] y, logic [1:0] pick);
    cell_result_t r;
    int unsigned  w, h, nx, ny, k;
    logic [3:0]   d, opp, back;
    bit           hit;
    w = fit_dim(grid_w_reg);
    h = fit_dim(grid_h_reg);
    r = '0;
    hit = 1'b0;
    nx = 0;
    ny = 0;
    d = '0;
    case (req)
      REQ_START: begin
        foreach (cell_mem[i]) cell_mem[i] = '0;
        walk_x = clamp(x, w);
        walk_y = clamp(y, h);
        carving = 1'b1;
        r.ev = EV_STARTED;
        r.px = walk_x;
        r.py = walk_y;
      end
      REQ_STEP: begin
        walk_x = clamp(walk_x, w);
        walk_y = clamp(walk_y, h);
        r.ev = EV_FINISHED;
        if (carving) begin
          d = 4'b0001 << pick;
          for (k = 0; k < 4; k++) begin
            if (hop(walk_x, walk_y, d, nx, ny) && cell_mem[nx + w*ny] == 8'd0) begin
              hit = 1'b1;
              break;
            end
            d = {d[2:0], d[3]};
          end
          if (hit) begin
            opp = {d[1:0], d[3:2]};
            cell_mem[walk_x + w*walk_y] = cell_mem[walk_x + w*walk_y] | {4'h0, d};
            walk_x = nx;
            walk_y = ny;
            cell_mem[nx + w*ny] = {opp, opp};
            r.ev = EV_CARVED;
            r.dir = d;
          end else begin
            back = cell_mem[walk_x + w*walk_y][7:4];
            if (back == DIR_UP || back == DIR_RIGHT || back == DIR_DOWN || back == DIR_LEFT) begin
              // a move back past the edge (grid shrunk) stays put
              if (hop(walk_x, walk_y, back, nx, ny)) begin
                walk_x = nx;
                walk_y = ny;
              end
              r.ev = EV_BACKTRACKED;
              r.dir = back;
            end else begin
              carving = 1'b0;
            end
          end
        end
        r.px = walk_x;
        r.py = walk_y;
        r.val = cell_mem[walk_x + w*walk_y];
      end
      default: begin
        r.ev = EV_READ_REPLY;
        r.px = clamp(x, w);
        r.py = clamp(y, h);
        r.val = cell_mem[clamp(x, w) + w*clamp(y, h)];
      end
    endcase
    return r;
  endfunction

  function automatic int unsigned idle_len(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < PRINT_CAP)
      $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(logic [2:0] ev, logic [OUT_DATA_W-1:0] data);
    cell_result_t want;
    if (awaited.size() == 0) begin
      report_mismatch("word with nothing awaited, event", ev, 0);
      return;
    end
    want = awaited.pop_front();
    if (ev !== want.ev) report_mismatch("event_res", ev, want.ev);
    if (data[5:0] !== want.px) report_mismatch("pos_x", data[5:0], want.px);
    if (data[11:6] !== want.py) report_mismatch("pos_y", data[11:6], want.py);
    if (data[15:12] !== want.dir) report_mismatch("direction", data[15:12], want.dir);
    if (data[23:16] !== want.val) report_mismatch("cell_value", data[23:16], want.val);
  endtask

  // output side: check, then pick the next ready pattern
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tuser, m_axis_tdata);
    if ($urandom_range(0, 299) == 0) rx_calm <= !rx_calm;
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      rx_wait <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      rx_wait <= idle_len(rx_calm);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_maze_backtracker_generator_core NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(logic [1:0] req, logic [5:0] x, logic [5:0] y, logic [1:0] pick,
                           bit typed, cell_result_t want);
    cell_result_t guess;
    int unsigned  gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, pick, y, x};
    s_axis_tuser <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    guess = carve_predict(req, x, y, pick);
    awaited.push_back(typed ? want : guess);
    words_sent++;
    gap = idle_len(tx_calm);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
  endtask

  // both registers are written back to back while the core is idle
  task automatic set_grid(logic [6:0] w, logic [6:0] h);
    settle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_GRID_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    grid_w_reg = w;
    cfg_index_i <= CFG_GRID_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    grid_h_reg = h;
    cfg_we_i <= 1'b0;
  endtask

  function automatic void plan_grid(logic [6:0] w, logic [6:0] h);
    plan_row_t row;
    row.kind = ROW_GRID;
    row.gw = w;
    row.gh = h;
    row.req = REQ_READ;
    row.x = '0;
    row.y = '0;
    row.pick = '0;
    row.typed = 1'b0;
    row.want = '0;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_item(logic [1:0] req, logic [5:0] x, logic [5:0] y,
                                    logic [1:0] pick, bit typed, cell_result_t want);
    plan_row_t row;
    row.kind = ROW_WORD;
    row.gw = '0;
    row.gh = '0;
    row.req = req;
    row.x = x;
    row.y = y;
    row.pick = pick;
    row.typed = typed;
    row.want = want;
    directed_plan.push_back(row);
  endfunction

  initial begin
    int unsigned r, n, steps, cells, phase;
    logic [6:0]  gw, gh;

    // reset state, extremes of the coordinates, the spare request code
    plan_item(REQ_READ, 0, 0, PICK_UP, 1, '{EV_READ_REPLY, 6'd0, 6'd0, 4'd0, 8'd0});
    plan_item(REQ_STEP, 0, 0, PICK_UP, 1, '{EV_FINISHED, 6'd0, 6'd0, 4'd0, 8'd0});
    plan_item(REQ_READ, 63, 63, PICK_LEFT, 1, '{EV_READ_REPLY, 6'd63, 6'd63, 4'd0, 8'd0});
    plan_item(REQ_SPARE, 5, 7, PICK_LEFT, 1, '{EV_READ_REPLY, 6'd5, 6'd7, 4'd0, 8'd0});
    // width below range, height above range: saturate to 1 and 64
    plan_grid(7'd0, 7'd127);
    plan_item(REQ_READ, 63, 63, PICK_UP, 1, '{EV_READ_REPLY, 6'd0, 6'd63, 4'd0, 8'd0});
    plan_item(REQ_START, 40, 40, PICK_UP, 1, '{EV_STARTED, 6'd0, 6'd40, 4'd0, 8'd0});
    plan_item(REQ_STEP, 0, 0, PICK_RIGHT, 0, '0);
    plan_item(REQ_STEP, 0, 0, PICK_LEFT, 0, '0);
    plan_item(REQ_STEP, 0, 0, PICK_UP, 0, '0);
    // 2x2 maze carved to completion, then a step after finishing
    plan_grid(7'd2, 7'd2);
    plan_item(REQ_START, 63, 63, PICK_DOWN, 1, '{EV_STARTED, 6'd1, 6'd1, 4'd0, 8'd0});
    plan_item(REQ_STEP, 0, 0, PICK_UP, 0, '0);
    plan_item(REQ_STEP, 0, 0, PICK_RIGHT, 0, '0);
    plan_item(REQ_STEP, 0, 0, PICK_DOWN, 0, '0);
    plan_item(REQ_STEP, 0, 0, PICK_LEFT, 0, '0);
    plan_item(REQ_STEP, 0, 0, PICK_UP, 0, '0);
    plan_item(REQ_STEP, 0, 0, PICK_RIGHT, 0, '0);
    plan_item(REQ_STEP, 0, 0, PICK_DOWN, 0, '0);
    plan_item(REQ_STEP, 0, 0, PICK_LEFT, 0, '0);
    plan_item(REQ_READ, 1, 0, PICK_UP, 0, '0);
    // single row, then shrink the grid under the walker
    plan_grid(7'd64, 7'd1);
    plan_item(REQ_START, 0, 0, PICK_UP, 1, '{EV_STARTED, 6'd0, 6'd0, 4'd0, 8'd0});
    plan_item(REQ_STEP, 0, 0, PICK_LEFT, 0, '0);
    plan_item(REQ_STEP, 0, 0, PICK_DOWN, 0, '0);
    plan_grid(7'd3, 7'd3);
    plan_item(REQ_STEP, 0, 0, PICK_DOWN, 0, '0);
    plan_item(REQ_READ, 63, 63, PICK_UP, 0, '0);
    plan_item(REQ_STEP, 0, 0, PICK_UP, 0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_GRID)
        set_grid(directed_plan[i].gw, directed_plan[i].gh);
      else
        send_word(directed_plan[i].req, directed_plan[i].x, directed_plan[i].y,
                  directed_plan[i].pick, directed_plan[i].typed, directed_plan[i].want);
    end

    phase = 0;
    while (words_sent < ITEM_TARGET) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        gw = $urandom_range(1, 8);
        gh = $urandom_range(1, 8);
      end else if (r < 80) begin
        gw = $urandom_range(1, 64);
        gh = $urandom_range(1, 64);
      end else if (r < 92) begin
        gw = rim_dims[$urandom_range(0, 6)];
        gh = rim_dims[$urandom_range(0, 6)];
      end else begin
        gw = $urandom_range(0, 127);
        gh = $urandom_range(0, 127);
      end
      // the settle inside set_grid also drains all pending words
      set_grid(gw, gh);
      // some phases keep carving the previous maze on the new grid
      if ($urandom_range(0, 9) < 8)
        send_word(REQ_START, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 3), 0, '0);

      if (phase == 1) begin
        // long output stall while reads keep coming: the core must back up
        tx_calm = 1'b1;
        hold_req <= !hold_req;
        repeat (12)
          send_word(REQ_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 3), 0, '0);
      end

      cells = fit_dim(gw) * fit_dim(gh);
      steps = (2*cells + 4 > 150) ? 150 : 2*cells + $urandom_range(1, 6);
      for (n = 0; n < steps; n++) begin
        r = $urandom_range(0, 99);
        if (r < 80)
          send_word(REQ_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 3), 0, '0);
        else if (r < 92)
          send_word(REQ_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 3), 0, '0);
        else if (r < 97)
          send_word(REQ_SPARE, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 3), 0, '0);
        else
          send_word(REQ_START, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 3), 0, '0);
      end
      phase++;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (awaited.size() != 0) report_mismatch("words never returned", awaited.size(), 0);
    if (mismatches == 0)
      $display("tb_maze_backtracker_generator_core OK");
    else
      $display("tb_maze_backtracker_generator_core NOT OK");
    $finish;
  end

endmodule

// File: maze_backtracker_generator_core.f
+incdir+hw/rtl
hw/rtl/mbg_pkg.sv
hw/rtl/maze_backtracker_generator_core.sv
bench/tb_maze_backtracker_generator_core.sv
